// ===== src/dpsc_pkg.sv =====
package dpsc_pkg;

   localparam int SUM_W   = 11;
   localparam int TERM_W  = 5;
   localparam int COUNT_W = 32;

   localparam logic [COUNT_W-1:0] SAT_LIMIT = '1;

   typedef struct packed {
      logic [SUM_W-1:0]  target_sum;
      logic [TERM_W-1:0] term_count;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] way_count;
      logic               count_saturated;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic              out_of_range;
      logic [SUM_W-1:0]  target_sum;
      logic [TERM_W-1:0] term_count;
   } query_type;

endpackage

// ===== src/dpsc_front.sv =====
module dpsc_front #(
   parameter int MAX_SUM   = 1024,
   parameter int MAX_TERMS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dpsc_pkg::req_type   req_item,
   output logic                q_valid,
   input  logic                q_ready,
   output dpsc_pkg::query_type q_item
);
   import dpsc_pkg::*;

   logic      ent_valid_ff;
   logic      ent_valid_in;
   query_type ent_ff;
   query_type ent_in;
   logic      oor;

   assign oor = (32'(req_item.target_sum) > 32'(MAX_SUM)) ||
                (32'(req_item.term_count) > 32'(MAX_TERMS));

   assign req_ready = !ent_valid_ff || q_ready;
   assign q_valid   = ent_valid_ff;
   assign q_item    = ent_ff;

   always_comb begin
      ent_valid_in = ent_valid_ff;
      ent_in       = ent_ff;
      if (ent_valid_ff && q_ready) begin
         ent_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         ent_valid_in        = 1'b1;
         ent_in.out_of_range = oor;
         ent_in.target_sum   = req_item.target_sum;
         ent_in.term_count   = req_item.term_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
      end
      ent_ff <= ent_in;
   end

endmodule

// ===== src/dpsc_queue.sv =====
module dpsc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  dpsc_pkg::query_type push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output dpsc_pkg::query_type pop_item
);
   import dpsc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   query_type         slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW-1:0]     rd_ptr_in;
   logic [NW-1:0]     count_ff;
   logic [NW-1:0]     count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != NW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/dpsc_back.sv =====
module dpsc_back #(
   parameter int MAX_SUM   = 1024,
   parameter int MAX_TERMS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  dpsc_pkg::query_type q_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dpsc_pkg::rsp_type   rsp_item
);
   import dpsc_pkg::*;

   localparam int ROW_LEN = MAX_TERMS + 1;
   localparam int TD      = (MAX_SUM + 1) * ROW_LEN;
   localparam int AW      = $clog2(TD);
   localparam int SW      = $clog2(MAX_SUM + 1);
   localparam int CW      = SW + 1;
   localparam int KW      = $clog2(MAX_TERMS + 1);
   localparam int SQW     = 2 * CW;

   typedef enum logic [3:0] {
      ST_IDLE,
      SV_INIT,
      SV_RD,
      SV_CHK,
      SV_CLR,
      TB_CLR,
      PR_RD,
      PR_CHK,
      DP_RD,
      DP_WR,
      ST_READY
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [CW-1:0]      p_ff;
   logic [CW-1:0]      p_in;
   logic [CW-1:0]      s_ff;
   logic [CW-1:0]      s_in;
   logic [KW-1:0]      k_ff;
   logic [KW-1:0]      k_in;
   logic [AW-1:0]      dst_ff;
   logic [AW-1:0]      dst_in;
   logic [AW-1:0]      src_ff;
   logic [AW-1:0]      src_in;
   logic               pend_ff;
   logic               pend_in;
   logic               pend_oor_ff;
   logic               pend_oor_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_item_ff;
   rsp_type            rsp_item_in;

   logic               mark_mem [0:MAX_SUM];
   logic               mark_we;
   logic [SW-1:0]      mark_waddr;
   logic               mark_wdata;
   logic [SW-1:0]      mark_raddr;
   logic               mark_rd_ff;

   logic [COUNT_W-1:0] way_mem [0:TD-1];
   logic               way_we;
   logic [AW-1:0]      way_waddr;
   logic [COUNT_W-1:0] way_wdata;
   logic [AW-1:0]      way_raddr_a;
   logic [AW-1:0]      way_raddr_b;
   logic [COUNT_W-1:0] way_a_ff;
   logic [COUNT_W-1:0] way_b_ff;

   logic [SQW-1:0]     sq;
   logic [CW-1:0]      j_next;
   logic [AW-1:0]      p_row;
   logic [AW-1:0]      q_addr;
   logic [COUNT_W:0]   sat_sum;
   logic               pop;

   assign sq      = SQW'(p_ff) * SQW'(p_ff);
   assign j_next  = s_ff + p_ff;
   assign p_row   = AW'(p_ff) * AW'(ROW_LEN);
   assign q_addr  = q_item.out_of_range ? '0 :
                    AW'(AW'(q_item.target_sum) * AW'(ROW_LEN) + AW'(q_item.term_count));
   assign sat_sum = {1'b0, way_a_ff} + {1'b0, way_b_ff};

   assign pop     = (state_ff == ST_READY) && q_valid && !pend_ff &&
                    (!rsp_valid_ff || rsp_ready);
   assign q_ready = pop;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign mark_raddr  = p_ff[SW-1:0];
   assign way_raddr_a = (state_ff == ST_READY) ? q_addr : dst_ff;
   assign way_raddr_b = src_ff;

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      s_in         = s_ff;
      k_in         = k_ff;
      dst_in       = dst_ff;
      src_in       = src_ff;
      pend_in      = pend_ff;
      pend_oor_in  = pend_oor_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      mark_we      = 1'b0;
      mark_waddr   = p_ff[SW-1:0];
      mark_wdata   = 1'b0;
      way_we       = 1'b0;
      way_waddr    = dst_ff;
      way_wdata    = sat_sum[COUNT_W] ? SAT_LIMIT : sat_sum[COUNT_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_ff) begin
         pend_in                     = 1'b0;
         rsp_valid_in                = 1'b1;
         rsp_item_in.out_of_range    = pend_oor_ff;
         rsp_item_in.way_count       = pend_oor_ff ? '0 : way_a_ff;
         rsp_item_in.count_saturated = !pend_oor_ff && (way_a_ff == SAT_LIMIT);
      end
      if (pop) begin
         pend_in     = 1'b1;
         pend_oor_in = q_item.out_of_range;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               p_in     = '0;
               state_in = SV_INIT;
            end
         end
         SV_INIT: begin
            mark_we    = 1'b1;
            mark_wdata = p_ff >= CW'(2);
            if (p_ff == CW'(MAX_SUM)) begin
               p_in     = CW'(2);
               state_in = SV_RD;
            end else begin
               p_in = p_ff + CW'(1);
            end
         end
         SV_RD: begin
            if (sq > SQW'(MAX_SUM)) begin
               dst_in   = '0;
               state_in = TB_CLR;
            end else begin
               state_in = SV_CHK;
            end
         end
         SV_CHK: begin
            if (mark_rd_ff) begin
               s_in     = CW'(sq);
               state_in = SV_CLR;
            end else begin
               p_in     = p_ff + CW'(1);
               state_in = SV_RD;
            end
         end
         SV_CLR: begin
            mark_we    = 1'b1;
            mark_waddr = s_ff[SW-1:0];
            s_in       = j_next;
            if (j_next > CW'(MAX_SUM)) begin
               p_in     = p_ff + CW'(1);
               state_in = SV_RD;
            end
         end
         TB_CLR: begin
            way_we    = 1'b1;
            way_wdata = (dst_ff == '0) ? COUNT_W'(1) : '0;
            if (dst_ff == AW'(TD - 1)) begin
               p_in     = CW'(2);
               state_in = PR_RD;
            end else begin
               dst_in = dst_ff + AW'(1);
            end
         end
         PR_RD: begin
            if (p_ff > CW'(MAX_SUM)) begin
               state_in = ST_READY;
            end else begin
               state_in = PR_CHK;
            end
         end
         PR_CHK: begin
            if (mark_rd_ff) begin
               s_in     = CW'(MAX_SUM);
               k_in     = KW'(MAX_TERMS);
               dst_in   = AW'(TD - 1);
               src_in   = AW'(TD - 2) - p_row;
               state_in = DP_RD;
            end else begin
               p_in     = p_ff + CW'(1);
               state_in = PR_RD;
            end
         end
         DP_RD: begin
            state_in = DP_WR;
         end
         DP_WR: begin
            way_we = 1'b1;
            if (k_ff == KW'(1)) begin
               if (s_ff == p_ff) begin
                  p_in     = p_ff + CW'(1);
                  state_in = PR_RD;
               end else begin
                  s_in     = s_ff - CW'(1);
                  k_in     = KW'(MAX_TERMS);
                  dst_in   = dst_ff - AW'(2);
                  src_in   = src_ff - AW'(2);
                  state_in = DP_RD;
               end
            end else begin
               k_in     = k_ff - KW'(1);
               dst_in   = dst_ff - AW'(1);
               src_in   = src_ff - AW'(1);
               state_in = DP_RD;
            end
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff        <= p_in;
      s_ff        <= s_in;
      k_ff        <= k_in;
      dst_ff      <= dst_in;
      src_ff      <= src_in;
      pend_oor_ff <= pend_oor_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      mark_rd_ff <= mark_mem[mark_raddr];
   end

   always_ff @(posedge clock) begin
      if (way_we) begin
         way_mem[way_waddr] <= way_wdata;
      end
      way_a_ff <= way_mem[way_raddr_a];
      way_b_ff <= way_mem[way_raddr_b];
   end

endmodule

// ===== src/distinct_prime_sum_counter.sv =====
// An accepted item passes the front register and the queue; once the table is built, the back
// end reads its table entry and registers the result, taking no new item while one is pending.
// The first item after reset waits for the table build: a prime sieve, a clear of all
// (MAX_SUM+1)*(MAX_TERMS+1) table entries, then a table read and a table write per update.
// Reset clears the control state and marks the table unbuilt; the next item rebuilds it.
module distinct_prime_sum_counter #(
   parameter int MAX_SUM   = 1024,
   parameter int MAX_TERMS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dpsc_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dpsc_pkg::rsp_type rsp_item
);
   import dpsc_pkg::*;

   logic      fq_valid;
   logic      fq_ready;
   query_type fq_item;
   logic      qb_valid;
   logic      qb_ready;
   query_type qb_item;

   dpsc_front #(
      .MAX_SUM   (MAX_SUM),
      .MAX_TERMS (MAX_TERMS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_valid   (fq_valid),
      .q_ready   (fq_ready),
      .q_item    (fq_item)
   );

   dpsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   dpsc_back #(
      .MAX_SUM   (MAX_SUM),
      .MAX_TERMS (MAX_TERMS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (qb_valid),
      .q_ready   (qb_ready),
      .q_item    (qb_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== sim/distinct_prime_sum_counter_tb.sv =====
`timescale 1ns / 100ps

module distinct_prime_sum_counter_tb;
   import dpsc_pkg::*;

   localparam int MAX_SUM   = 1024;
   localparam int MAX_TERMS = 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;

   bit                 is_prime [0:MAX_SUM];
   logic [COUNT_W-1:0] way_ref  [0:MAX_SUM][0:MAX_TERMS];

   rsp_type pending_answers[$];
   bit      idle_on;
   int      mismatch_count;
   int      queries_sent;
   int      out_of_range_sent;
   int      nonzero_seen;
   int      answers_seen;

   distinct_prime_sum_counter #(
      .MAX_SUM   (MAX_SUM),
      .MAX_TERMS (MAX_TERMS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(200_000_000);
      $display("simulation failed");
      $finish;
   end

   function automatic rsp_type count_prime_sets(req_type q);
      rsp_type a;
      a = '0;
      if (q.target_sum > MAX_SUM || q.term_count > MAX_TERMS) begin
         a.out_of_range = 1'b1;
      end else begin
         a.way_count       = way_ref[q.target_sum][q.term_count];
         a.count_saturated = (a.way_count == SAT_LIMIT);
      end
      return a;
   endfunction

   task automatic send_query(input int sum, input int terms);
      req_type q;
      q.target_sum = SUM_W'(sum);
      q.term_count = TERM_W'(terms);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= q;
      do @(posedge clock); while (!req_ready);
      pending_answers = {pending_answers, count_prime_sets(q)};
      queries_sent++;
      if (sum > MAX_SUM || terms > MAX_TERMS) out_of_range_sent++;
   endtask

   task automatic send_random_query();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         send_query($urandom_range(0, MAX_SUM), $urandom_range(0, MAX_TERMS));
      else if (pick < 70)
         send_query($urandom_range(0, MAX_SUM), $urandom_range(1, 8));
      else if (pick < 80)
         send_query($urandom_range(MAX_SUM - 24, MAX_SUM), $urandom_range(0, MAX_TERMS));
      else if (pick < 90)
         send_query($urandom_range(MAX_SUM + 1, 2047), $urandom_range(0, 31));
      else
         send_query($urandom_range(0, 2047), $urandom_range(MAX_TERMS + 1, 31));
   endtask

   task automatic check_answer(input rsp_type got);
      rsp_type want;
      if (pending_answers.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: unexpected item count=%0d sat=%0b oor=%0b", $realtime,
                     got.way_count, got.count_saturated, got.out_of_range);
         return;
      end
      want = pending_answers.pop_front();
      answers_seen++;
      if (got.way_count != 0) nonzero_seen++;
      if (got.way_count !== want.way_count ||
          got.count_saturated !== want.count_saturated ||
          got.out_of_range !== want.out_of_range) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: mismatch count exp=%0d got=%0d sat exp=%0b got=%0b oor exp=%0b got=%0b",
                     $realtime, want.way_count, got.way_count, want.count_saturated,
                     got.count_saturated, want.out_of_range, got.out_of_range);
      end
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) check_answer(rsp_item);
         if (idle_on && stall_left == 0 && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 13);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic test_first_query_builds();
      send_query(2047, 31);
      send_query(0, 0);
   endtask

   task automatic test_field_extremes();
      send_query(MAX_SUM, 0);
      send_query(0, MAX_TERMS);
      send_query(MAX_SUM, MAX_TERMS);
      send_query(MAX_SUM, 1);
      send_query(MAX_SUM - 1, 1);
      send_query(381, MAX_TERMS);
      send_query(MAX_SUM, MAX_TERMS - 1);
      send_query(1, 1);
   endtask

   task automatic test_out_of_range();
      send_query(MAX_SUM + 1, 0);
      send_query(MAX_SUM + 1, MAX_TERMS);
      send_query(0, MAX_TERMS + 1);
      send_query(MAX_SUM, MAX_TERMS + 1);
      send_query(2047, 0);
      send_query(0, 31);
      send_query(1536, 20);
   endtask

   task automatic test_small_sums();
      send_query(2, 1);
      send_query(5, 2);
      send_query(4, 2);
      send_query(24, 3);
      send_query(17, 4);
      send_query(18, 3);
   endtask

   task automatic test_random_queries(input int count);
      repeat (count) send_random_query();
   endtask

   task automatic test_drain_pause(input int count);
      repeat (count) send_random_query();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat ($urandom_range(1, 13)) @(posedge clock);
      repeat (count) send_random_query();
   endtask

   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      repeat (count) send_random_query();
   endtask

   initial begin
      int p;
      int s;
      int k;
      logic [COUNT_W:0] acc;

      for (s = 0; s <= MAX_SUM; s++) is_prime[s] = (s >= 2);
      for (p = 2; p * p <= MAX_SUM; p++)
         if (is_prime[p])
            for (s = p * p; s <= MAX_SUM; s += p) is_prime[s] = 1'b0;
      for (s = 0; s <= MAX_SUM; s++)
         for (k = 0; k <= MAX_TERMS; k++) way_ref[s][k] = '0;
      way_ref[0][0] = COUNT_W'(1);
      for (p = 2; p <= MAX_SUM; p++) begin
         if (!is_prime[p]) continue;
         for (s = MAX_SUM; s >= p; s--)
            for (k = MAX_TERMS; k >= 1; k--) begin
               acc = {1'b0, way_ref[s][k]} + {1'b0, way_ref[s - p][k - 1]};
               way_ref[s][k] = acc[COUNT_W] ? SAT_LIMIT : acc[COUNT_W-1:0];
            end
      end

      idle_on           = 1'b1;
      mismatch_count    = 0;
      queries_sent      = 0;
      out_of_range_sent = 0;
      nonzero_seen      = 0;
      answers_seen      = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_item  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_first_query_builds();
      test_field_extremes();
      test_out_of_range();
      test_small_sums();
      test_random_queries(560);
      test_drain_pause(40);
      test_back_to_back(70);

      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d queries sent after one table build, %0d of them out of bounds",
               queries_sent, out_of_range_sent);
      $display("%0d answers checked, %0d with a nonzero count, %0d mismatches",
               answers_seen, nonzero_seen, mismatch_count);
      if (mismatch_count == 0 && pending_answers.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
